FILE: rtl/core/bpe_pkg.sv
package bpe_pkg;

   // Default size of the control point table.
   localparam int MAX_POINTS_DEF = 16;

   // Field widths of the request and response beats.
   localparam int COORD_W = 16;
   localparam int T_W     = 17;
   localparam int DEG_W   = 4;
   localparam int IDX_IN_W = 4;
   localparam int OUT_W   = 24;

   // Working values are Q16.24, one guard bit is enough for a difference.
   localparam int WORK_FRAC = 24;
   localparam int WORK_W    = COORD_W + WORK_FRAC;
   localparam int DIFF_W    = WORK_W + 1;
   localparam int PROD_W    = DIFF_W + T_W + 1;

   // Rounding of a Q.16 product back to the working scale.
   localparam int RND_SHIFT = 16;
   localparam logic [T_W-1:0] T_ONE = T_W'(65536);

   // Operation codes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // Spans the path from a read of the working store, through its read register and the two
   // interpolation stages, to the write of the value it produces, so a later read sees it.
   localparam int WR_LATENCY = 4;

endpackage

FILE: rtl/core/bpe_ram.sv
module bpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port; read data holds while idle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/core/bpe_lerp_unit.sv
module bpe_lerp_unit #(
   parameter int IDX_W = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step_valid,
   input  logic [IDX_W-1:0]                     step_addr,
   input  logic signed [bpe_pkg::WORK_W-1:0]    a_x,
   input  logic signed [bpe_pkg::WORK_W-1:0]    b_x,
   input  logic signed [bpe_pkg::WORK_W-1:0]    a_y,
   input  logic signed [bpe_pkg::WORK_W-1:0]    b_y,
   input  logic [bpe_pkg::T_W-1:0]              t_param,
   output logic                                 wr_en,
   output logic [IDX_W-1:0]                     wr_addr,
   output logic signed [bpe_pkg::WORK_W-1:0]    wr_x,
   output logic signed [bpe_pkg::WORK_W-1:0]    wr_y
);

   localparam logic signed [bpe_pkg::PROD_W-1:0] RND_HALF =
      bpe_pkg::PROD_W'(1) <<< (bpe_pkg::RND_SHIFT - 1);

   logic                                  v1_ff, v2_ff;
   logic [IDX_W-1:0]                      addr1_ff, addr2_ff;
   logic signed [bpe_pkg::DIFF_W-1:0]     d_x_ff, d_y_ff;
   logic signed [bpe_pkg::WORK_W-1:0]     a1_x_ff, a1_y_ff, a2_x_ff, a2_y_ff;
   logic signed [bpe_pkg::PROD_W-1:0]     p_x_ff, p_y_ff;
   logic signed [bpe_pkg::PROD_W-1:0]     t_s;
   logic signed [bpe_pkg::PROD_W-1:0]     r_x, r_y;

   assign t_s = $signed({{(bpe_pkg::PROD_W - bpe_pkg::T_W){1'b0}}, t_param});

   // Valid flags of the two pipeline stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= step_valid;
         v2_ff <= v1_ff;
      end
   end

   // First stage takes the difference, second stage scales it by t.
   always_ff @(posedge clock) begin
      addr1_ff <= step_addr;
      a1_x_ff  <= a_x;
      a1_y_ff  <= a_y;
      d_x_ff   <= bpe_pkg::DIFF_W'(b_x) - bpe_pkg::DIFF_W'(a_x);
      d_y_ff   <= bpe_pkg::DIFF_W'(b_y) - bpe_pkg::DIFF_W'(a_y);
      addr2_ff <= addr1_ff;
      a2_x_ff  <= a1_x_ff;
      a2_y_ff  <= a1_y_ff;
      p_x_ff   <= bpe_pkg::PROD_W'(d_x_ff) * t_s;
      p_y_ff   <= bpe_pkg::PROD_W'(d_y_ff) * t_s;
   end

   // Round the scaled difference to nearest, ties upward, and add it back.
   assign r_x = (p_x_ff + RND_HALF) >>> bpe_pkg::RND_SHIFT;
   assign r_y = (p_y_ff + RND_HALF) >>> bpe_pkg::RND_SHIFT;

   assign wr_en   = v2_ff;
   assign wr_addr = addr2_ff;
   assign wr_x    = a2_x_ff + r_x[bpe_pkg::WORK_W-1:0];
   assign wr_y    = a2_y_ff + r_y[bpe_pkg::WORK_W-1:0];

endmodule

FILE: rtl/core/bezier_point_evaluator_unit.sv
// Channel   Direction  Beat contents
// req_      in         op, point_index, point_x, point_y, t_param, degree
// rsp_      out        pos_x, pos_y (one beat per evaluate, none per load)
//
// A load beat is accepted in the idle state, which it does not leave. An evaluate of
// degree n makes (n+1)(n+2)/2 reads of the working store, one per cycle within a level,
// with an idle gap after each level from one to three, then the drain and done states.
// Reset is synchronous and clears only the sequencer state and the valid flags.
// A waiting response beat does not block new request beats; a finished
// evaluate waits in its last state until the response register is free.
module bezier_point_evaluator_unit #(
   parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [bpe_pkg::IDX_IN_W-1:0]        req_point_index,
   input  logic signed [bpe_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [bpe_pkg::COORD_W-1:0]  req_point_y,
   input  logic [bpe_pkg::T_W-1:0]             req_t_param,
   input  logic [bpe_pkg::DEG_W-1:0]           req_degree,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [bpe_pkg::OUT_W-1:0]    rsp_pos_x,
   output logic signed [bpe_pkg::OUT_W-1:0]    rsp_pos_y
);

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int WIDE_W = 6;
   localparam int GAP_W  = 3;
   localparam int CW     = bpe_pkg::COORD_W;
   localparam int WW     = bpe_pkg::WORK_W;
   localparam logic [WIDE_W-1:0] LAST_IDX = WIDE_W'(MAX_POINTS - 1);
   localparam logic [WIDE_W-1:0] TABLE_SZ = WIDE_W'(MAX_POINTS);
   localparam logic [WIDE_W-1:0] GAP_LIM  = WIDE_W'(bpe_pkg::WR_LATENCY);
   localparam logic signed [WW-1:0] OUT_HALF = WW'(1) <<< (bpe_pkg::RND_SHIFT - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_GAP   = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type                   st_ff, st_in;
   logic [IDX_W-1:0]            lvl_ff, lvl_in, addr_ff, addr_in, n_ff, n_in;
   logic [GAP_W-1:0]            gap_ff, gap_in, gap_need;
   logic [bpe_pkg::T_W-1:0]     t_ff, t_in;
   logic [WIDE_W-1:0]           idx_wide, deg_wide, lvl_wide;
   logic                        acc, acc_load, acc_eval;

   logic                        s1_valid_ff, s1_first_ff, s1_final_ff, s1_src_ff;
   logic [IDX_W-1:0]            s1_addr_ff;

   logic [2*CW-1:0]             ctrl_rd;
   logic [2*WW-1:0]             work_rd;
   logic signed [WW-1:0]        cur_x, cur_y, prev_x_ff, prev_y_ff;
   logic signed [WW-1:0]        fin_x, fin_y;
   logic signed [bpe_pkg::OUT_W-1:0] res_x_ff, res_y_ff;
   logic                        rsp_valid_ff;
   logic signed [bpe_pkg::OUT_W-1:0] rsp_x_ff, rsp_y_ff;

   logic                        rd_en, step_valid, wr_en;
   logic [IDX_W-1:0]            step_addr, wr_addr;
   logic signed [WW-1:0]        wr_x, wr_y;

   // Request handshake and load decode.
   assign req_ready = (st_ff == ST_IDLE);
   assign acc       = req_valid && req_ready;
   assign acc_load  = acc && (req_op == bpe_pkg::OP_LOAD);
   assign acc_eval  = acc && (req_op == bpe_pkg::OP_EVAL);
   assign idx_wide  = WIDE_W'(req_point_index);
   assign deg_wide  = WIDE_W'(req_degree);
   assign lvl_wide  = WIDE_W'(lvl_ff);

   // Control point table, x in the upper half.
   bpe_ram #(
      .WIDTH (2*CW),
      .DEPTH (MAX_POINTS)
   ) u_ctrl_store (
      .clock   (clock),
      .wr_en   (acc_load && (idx_wide < TABLE_SZ)),
      .wr_addr (idx_wide[IDX_W-1:0]),
      .wr_data ({req_point_x, req_point_y}),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (ctrl_rd)
   );

   // Working values of the recursion, written back in place.
   bpe_ram #(
      .WIDTH (2*WW),
      .DEPTH (MAX_POINTS)
   ) u_work_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({wr_x, wr_y}),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (work_rd)
   );

   // Idle cycles needed after a short level so the next one reads fresh values.
   assign gap_need = (lvl_wide < GAP_LIM) ? GAP_W'(GAP_LIM - lvl_wide) : '0;

   // Sequencer: one read per cycle, level by level with idle gaps after short levels, then the final read of point 0.
   always_comb begin
      st_in   = st_ff;
      lvl_in  = lvl_ff;
      addr_in = addr_ff;
      gap_in  = gap_ff;
      n_in    = n_ff;
      t_in    = t_ff;
      case (st_ff)
         ST_IDLE: begin
            if (acc_eval) begin
               n_in    = (deg_wide > LAST_IDX) ? LAST_IDX[IDX_W-1:0] : deg_wide[IDX_W-1:0];
               t_in    = (req_t_param > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : req_t_param;
               lvl_in  = n_in;
               addr_in = '0;
               st_in   = ST_READ;
            end
         end
         ST_READ: begin
            if (addr_ff == lvl_ff) begin
               addr_in = '0;
               if (lvl_ff == '0) begin
                  st_in = ST_DRAIN;
               end else begin
                  lvl_in = lvl_ff - 1'b1;
                  if (gap_need != '0) begin
                     gap_in = gap_need;
                     st_in  = ST_GAP;
                  end
               end
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_GAP: begin
            gap_in = gap_ff - 1'b1;
            if (gap_ff == GAP_W'(1)) begin
               st_in = ST_READ;
            end
         end
         ST_DRAIN: begin
            st_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      lvl_ff  <= lvl_in;
      addr_ff <= addr_in;
      gap_ff  <= gap_in;
      n_ff    <= n_in;
      t_ff    <= t_in;
   end

   // Tags that travel with each read to the cycle its data arrives.
   assign rd_en = (st_ff == ST_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= rd_en;
      end
      if (rd_en) begin
         s1_first_ff <= (addr_ff == '0);
         s1_final_ff <= (lvl_ff == '0);
         s1_src_ff   <= (lvl_ff == n_ff);
         s1_addr_ff  <= addr_ff;
      end
   end

   // The first level reads the control points, widened to Q16.24.
   assign cur_x = s1_src_ff ? $signed({ctrl_rd[2*CW-1:CW], {bpe_pkg::WORK_FRAC{1'b0}}})
                            : $signed(work_rd[2*WW-1:WW]);
   assign cur_y = s1_src_ff ? $signed({ctrl_rd[CW-1:0], {bpe_pkg::WORK_FRAC{1'b0}}})
                            : $signed(work_rd[WW-1:0]);

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
      end
   end

   // Each pair of neighbours produces one new value for the lower slot.
   assign step_valid = s1_valid_ff && !s1_first_ff && !s1_final_ff;
   assign step_addr  = s1_addr_ff - 1'b1;

   bpe_lerp_unit #(
      .IDX_W (IDX_W)
   ) u_lerp (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .step_addr  (step_addr),
      .a_x        (prev_x_ff),
      .b_x        (cur_x),
      .a_y        (prev_y_ff),
      .b_y        (cur_y),
      .t_param    (t_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_x       (wr_x),
      .wr_y       (wr_y)
   );

   // Final rounding of point 0 to Q16.8.
   assign fin_x = (cur_x + OUT_HALF) >>> bpe_pkg::RND_SHIFT;
   assign fin_y = (cur_y + OUT_HALF) >>> bpe_pkg::RND_SHIFT;

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_final_ff) begin
         res_x_ff <= fin_x[bpe_pkg::OUT_W-1:0];
         res_y_ff <= fin_y[bpe_pkg::OUT_W-1:0];
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (st_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (st_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_x_ff <= res_x_ff;
         rsp_y_ff <= res_y_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = rsp_x_ff;
   assign rsp_pos_y = rsp_y_ff;

   // A write-back only happens while a level is being streamed.
   a_wr_in_run: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (st_ff == ST_READ || st_ff == ST_GAP))
      else $error("write-back outside an evaluation");

   // The working store is never read at the slot being written in the same cycle.
   a_no_raw: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (addr_ff != wr_addr))
      else $error("read and write of the same working slot");

   // An accepted evaluate beat starts the read stream at once.
   a_eval_start: assert property (@(posedge clock) disable iff (reset)
      acc_eval |=> (st_ff == ST_READ && addr_ff == '0))
      else $error("evaluate did not start");

   // Reads stay within the current level and the level within the degree.
   a_read_bounds: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_READ) |-> (addr_ff <= lvl_ff && lvl_ff <= n_ff))
      else $error("read address out of level");

   // A response beat appears only when an evaluation has finished.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff == ST_DONE))
      else $error("response without a finished evaluation");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int TABLE_SIZE  = bpe_pkg::MAX_POINTS_DEF;
   localparam int CLK_PERIOD  = 20;
   localparam int RESET_CYCLES = 8;
   localparam int IDLE_PCT    = 11;
   localparam int CYCLE_LIMIT = 1000000;
   // Run-out after the last result, long enough for one more degree-fifteen evaluate in flight.
   localparam int TAIL_CYCLES = 200;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_PRINTED = 100;
   localparam longint HALF_LSB = 64'sd32768;

   // One request beat and one response beat.
   typedef struct {
      logic                               op;
      logic [bpe_pkg::IDX_IN_W-1:0]       index;
      logic signed [bpe_pkg::COORD_W-1:0] x;
      logic signed [bpe_pkg::COORD_W-1:0] y;
      logic [bpe_pkg::T_W-1:0]            t;
      logic [bpe_pkg::DEG_W-1:0]          degree;
   } curve_req_type;

   typedef struct {
      logic signed [bpe_pkg::OUT_W-1:0] x;
      logic signed [bpe_pkg::OUT_W-1:0] y;
   } curve_point_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic                               req_op = bpe_pkg::OP_LOAD;
   logic [bpe_pkg::IDX_IN_W-1:0]       req_point_index = '0;
   logic signed [bpe_pkg::COORD_W-1:0] req_point_x = '0;
   logic signed [bpe_pkg::COORD_W-1:0] req_point_y = '0;
   logic [bpe_pkg::T_W-1:0]            req_t_param = '0;
   logic [bpe_pkg::DEG_W-1:0]          req_degree = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [bpe_pkg::OUT_W-1:0]   rsp_pos_x;
   logic signed [bpe_pkg::OUT_W-1:0]   rsp_pos_y;

   // Shadow copy of the control point table and the curve points still owed.
   logic signed [bpe_pkg::COORD_W-1:0] shadow_x [TABLE_SIZE];
   logic signed [bpe_pkg::COORD_W-1:0] shadow_y [TABLE_SIZE];
   curve_point_type                    pending_points [$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  n_loads = 0;
   int  n_evals = 0;
   int  n_checked = 0;
   int  hold_request = 0;
   bit  no_idle = 1'b0;

   bezier_point_evaluator_unit #(.MAX_POINTS(TABLE_SIZE)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_point_index (req_point_index),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_t_param     (req_t_param),
      .req_degree      (req_degree),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_points.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endtask

   // One axis of the curve point by repeated linear interpolation in Q16.24,
   // every step rounded to nearest with ties upwards, then rounded to Q16.8.
   function automatic logic signed [bpe_pkg::OUT_W-1:0] curve_axis(input bit use_x,
                                                                   input int unsigned deg,
                                                                   input longint t);
      longint w [TABLE_SIZE];
      longint r;
      int     k;
      int     lvl;
      for (k = 0; k <= deg; k++)
         w[k] = longint'(use_x ? shadow_x[k] : shadow_y[k]) * (64'sd1 <<< bpe_pkg::WORK_FRAC);
      for (lvl = deg; lvl > 0; lvl--) begin
         for (k = 0; k < lvl; k++)
            w[k] = w[k] + (((w[k + 1] - w[k]) * t + HALF_LSB) >>> bpe_pkg::RND_SHIFT);
      end
      r = (w[0] + HALF_LSB) >>> bpe_pkg::RND_SHIFT;
      return r[bpe_pkg::OUT_W-1:0];
   endfunction

   // Offers one beat, waits for it to be taken, then updates the shadow state.
   // Entered and left at a falling edge.
   task automatic send_beat(input curve_req_type b);
      longint          t_eff;
      int unsigned     deg;
      curve_point_type p;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= b.op;
      req_point_index <= b.index;
      req_point_x     <= b.x;
      req_point_y     <= b.y;
      req_t_param     <= b.t;
      req_degree      <= b.degree;
      do @(posedge clock); while (!req_ready);
      if (b.op == bpe_pkg::OP_LOAD) begin
         if (b.index < TABLE_SIZE) begin
            shadow_x[b.index] = b.x;
            shadow_y[b.index] = b.y;
         end
         n_loads++;
      end else begin
         // Parameters above one saturate, and the degree cannot exceed the table.
         t_eff = (b.t > bpe_pkg::T_ONE) ? longint'(bpe_pkg::T_ONE) : longint'(b.t);
         deg   = b.degree;
         if (deg > TABLE_SIZE - 1)
            deg = TABLE_SIZE - 1;
         p.x = curve_axis(1'b1, deg, t_eff);
         p.y = curve_axis(1'b0, deg, t_eff);
         pending_points.push_back(p);
         n_evals++;
      end
      @(negedge clock);
   endtask

   task automatic load_point(input int idx, input int px, input int py);
      curve_req_type b;
      b.op     = bpe_pkg::OP_LOAD;
      b.index  = bpe_pkg::IDX_IN_W'(idx);
      b.x      = bpe_pkg::COORD_W'(px);
      b.y      = bpe_pkg::COORD_W'(py);
      b.t      = bpe_pkg::T_W'($urandom);
      b.degree = bpe_pkg::DEG_W'($urandom);
      send_beat(b);
   endtask

   task automatic eval_at(input int deg, input int t);
      curve_req_type b;
      b.op     = bpe_pkg::OP_EVAL;
      b.index  = bpe_pkg::IDX_IN_W'($urandom);
      b.x      = bpe_pkg::COORD_W'($urandom);
      b.y      = bpe_pkg::COORD_W'($urandom);
      b.t      = bpe_pkg::T_W'(t);
      b.degree = bpe_pkg::DEG_W'(deg);
      send_beat(b);
   endtask

   // A random beat. Degrees lean towards small curves so that evaluates stay short,
   // and the parameter sometimes lands above one or on an edge.
   function automatic curve_req_type random_beat(input int load_pct);
      curve_req_type b;
      int            pick;
      b.op    = ($urandom_range(99) < load_pct) ? bpe_pkg::OP_LOAD : bpe_pkg::OP_EVAL;
      b.index = bpe_pkg::IDX_IN_W'($urandom);
      b.x     = bpe_pkg::COORD_W'($urandom);
      b.y     = bpe_pkg::COORD_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 80)
         b.t = bpe_pkg::T_W'($urandom_range(int'(bpe_pkg::T_ONE)));
      else if (pick < 90)
         b.t = bpe_pkg::T_W'($urandom);
      else begin
         case ($urandom_range(3))
            0: b.t = '0;
            1: b.t = bpe_pkg::T_W'(1);
            2: b.t = bpe_pkg::T_ONE - bpe_pkg::T_W'(1);
            default: b.t = bpe_pkg::T_ONE;
         endcase
      end
      pick = $urandom_range(99);
      if (pick < 70)
         b.degree = bpe_pkg::DEG_W'($urandom_range(4));
      else if (pick < 95)
         b.degree = bpe_pkg::DEG_W'($urandom_range(11, 5));
      else
         b.degree = bpe_pkg::DEG_W'($urandom_range(15, 12));
      return b;
   endfunction

   // Stops offering beats until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_points.size() != 0);
   endtask

   // Receiver: random stalls, a long hold-off on request, or always ready.
   always @(negedge clock) begin : drive_rsp_ready
      int hold_left;
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (no_idle)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
   end

   // Compare every response beat with the oldest owed curve point.
   always @(posedge clock) begin : check_results
      curve_point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0)
            report_error($sformatf("response beat x=%0d y=%0d with nothing owed",
                                   rsp_pos_x, rsp_pos_y));
         else begin
            want = pending_points.pop_front();
            n_checked++;
            if (rsp_pos_x !== want.x)
               report_error($sformatf("pos_x got %0d expected %0d", rsp_pos_x, want.x));
            if (rsp_pos_y !== want.y)
               report_error($sformatf("pos_y got %0d expected %0d", rsp_pos_y, want.y));
         end
      end
   end

   // Every slot is written before any evaluate, the coordinate extremes included.
   task automatic test_table_load();
      int i;
      load_point(0, -32768, 32767);
      for (i = 1; i < TABLE_SIZE - 1; i++)
         load_point(i, $urandom, $urandom);
      load_point(TABLE_SIZE - 1, 32767, -32768);
   endtask

   // Degree zero, the ends of the parameter range, saturation and the deepest curve.
   task automatic test_curve_corners();
      eval_at(0, 'h1FFFF);
      eval_at(1, 0);
      eval_at(1, int'(bpe_pkg::T_ONE));
      eval_at(1, 32768);
      eval_at(1, int'(bpe_pkg::T_ONE) + 1);
      eval_at(15, 1);
      eval_at(15, int'(bpe_pkg::T_ONE) - 1);
      eval_at(15, 'h1FFFF);
   endtask

   task automatic test_random_curves(input int count);
      int i;
      for (i = 0; i < count; i++)
         send_beat(random_beat(40));
   endtask

   // A stretch with no idling on either side.
   task automatic test_streaming(input int count);
      int i;
      no_idle = 1'b1;
      for (i = 0; i < count; i++)
         send_beat(random_beat(30));
      no_idle = 1'b0;
   endtask

   // The receiver holds off while evaluates keep coming, so the block fills and
   // stalls its input; afterwards the sender waits for everything to return.
   task automatic test_backpressure();
      int i;
      no_idle      = 1'b1;
      hold_request = HOLD_CYCLES;
      for (i = 0; i < 12; i++)
         eval_at($urandom_range(3, 1), $urandom_range(int'(bpe_pkg::T_ONE)));
      load_point($urandom_range(TABLE_SIZE - 1), $urandom, $urandom);
      eval_at($urandom_range(6), $urandom_range(int'(bpe_pkg::T_ONE)));
      drain_results();
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_table_load();
      test_curve_corners();
      test_random_curves(1200);
      test_streaming(150);
      test_backpressure();
      test_random_curves(20);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d point loads and %0d evaluates at degrees 0 to 15,",
               n_loads, n_evals);
      $display("%0d results checked, with saturated parameters, idle-free streaming %s",
               n_checked, "and a long response hold-off.");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/bpe_pkg.sv
rtl/core/bpe_ram.sv
rtl/core/bpe_lerp_unit.sv
rtl/core/bezier_point_evaluator_unit.sv
verif/testbench.sv
